// ===== hw/rtl/sbh_pkg.sv =====
// ----------------------------------------------------------------------------
// sbh_pkg
// shared types and constants for the byte stream sha-256 hasher
// ----------------------------------------------------------------------------
package sbh_pkg;

	// working variables a..h, index 0 is a
	typedef logic [7:0][31:0] work_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_ADD,
		ST_OUT
	} state_t;

	// controls for the message schedule window
	typedef struct packed {
		logic        push;
		logic        step;
		logic [31:0] word;
	} sched_ctl_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// ===== hw/rtl/sbh_sched.sv =====
// ----------------------------------------------------------------------------
// sbh_sched
// 16-word message schedule window, filled by pushes, extended one word per round
// ----------------------------------------------------------------------------
module sbh_sched (
	input  logic               clk,
	input  sbh_pkg::sched_ctl_t ctl,
	output logic [31:0]        w_cur
);

	logic [31:0] w_q [16];
	logic [31:0] s0;
	logic [31:0] s1;
	logic [31:0] w_new;
	logic [31:0] x;
	logic [31:0] y;

	always_comb begin
		x     = w_q[1];
		y     = w_q[14];
		s0    = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
		s1    = {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ {10'd0, y[31:10]};
		w_new = s1 + w_q[9] + s0 + w_q[0];
	end

	assign w_cur = w_q[0];

	// oldest word sits at index 0
	always_ff @(posedge clk) begin
		if (ctl.push || ctl.step) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= ctl.push ? ctl.word : w_new;
		end
	end

endmodule

// ===== hw/rtl/sbh_round.sv =====
// ----------------------------------------------------------------------------
// sbh_round
// one sha-256 compression round, shared across all 64 rounds
// ----------------------------------------------------------------------------
module sbh_round (
	input  sbh_pkg::work_t v,
	input  logic [31:0]    k,
	input  logic [31:0]    w,
	output sbh_pkg::work_t v_next
);

	logic [31:0] a;
	logic [31:0] e;
	logic [31:0] big0;
	logic [31:0] big1;
	logic [31:0] pick;
	logic [31:0] most;
	logic [31:0] t1;
	logic [31:0] t2;

	always_comb begin
		a    = v[0];
		e    = v[4];
		big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
		pick = (e & v[5]) ^ (~e & v[6]);
		t1   = v[7] + big1 + pick + k + w;
		big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
		most = (a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]);
		t2   = big0 + most;

		v_next[7] = v[6];
		v_next[6] = v[5];
		v_next[5] = v[4];
		v_next[4] = v[3] + t1;
		v_next[3] = v[2];
		v_next[2] = v[1];
		v_next[1] = v[0];
		v_next[0] = t1 + t2;
	end

endmodule

// ===== hw/rtl/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// sha-256 over a byte stream, one message byte per input word
// ----------------------------------------------------------------------------
// a byte word is taken while idle; the byte that fills a 64-byte block runs
//   the rounds and then the chaining add before the next word is taken
// end of message: one pad byte per cycle (up to 128 - fill), then one or two
//   compressions, then 8 digest words, one per cycle while out_ready is high
// no input is taken while a block is being compressed by the single round unit
// reset: chaining words load the initial hash values, counts clear, idle
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	// sequencer state
	sbh_pkg::state_t state_q;
	sbh_pkg::state_t state_nxt;

	// message bookkeeping
	logic [5:0]  fill_q;       // byte position inside the current block
	logic [60:0] total_q;      // message bytes, wraps like the 64-bit bit length
	logic        fin_q;        // message is being closed
	logic        mark_q;       // 0x80 marker already written
	logic        len_ok_q;     // current block is the one that carries the length
	logic [5:0]  rnd_q;        // round counter
	logic [2:0]  idx_q;        // digest word being shown
	logic [23:0] acc_q;        // bytes gathered toward the next big-endian word

	// chaining and working variables
	sbh_pkg::work_t h_q;
	sbh_pkg::work_t v_q;
	sbh_pkg::work_t v_round;

	// datapath glue
	logic                in_take;
	logic                absorb;
	logic                absorb_user;
	logic [7:0]          absorb_byte;
	logic [7:0]          pad_byte;
	logic [63:0]         len_shift;
	logic                comp_start;
	logic                out_take;
	logic [31:0]         w_cur;
	sbh_pkg::sched_ctl_t sched_ctl;

	assign in_take     = in_valid && in_ready;
	assign out_take    = out_valid && out_ready;
	assign absorb_user = in_take && byte_present;
	assign absorb      = absorb_user || (state_q == sbh_pkg::ST_PAD);

	// length bytes go out most significant first from position 56 on
	assign len_shift = {total_q, 3'b000} << {fill_q[2:0], 3'b000};

	always_comb begin
		if (!mark_q) begin
			pad_byte = sbh_pkg::PAD_MARK;
		end else if (len_ok_q && (fill_q >= sbh_pkg::LEN_POS)) begin
			pad_byte = len_shift[63:56];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign absorb_byte = (state_q == sbh_pkg::ST_PAD) ? pad_byte : data_byte;

	// every fourth byte completes a schedule word
	always_comb begin
		sched_ctl.push = absorb && (fill_q[1:0] == 2'b11);
		sched_ctl.step = (state_q == sbh_pkg::ST_COMP);
		sched_ctl.word = {acc_q, absorb_byte};
	end

	sbh_sched u_sched (
		.clk   (clk),
		.ctl   (sched_ctl),
		.w_cur (w_cur)
	);

	sbh_round u_round (
		.v      (v_q),
		.k      (sbh_pkg::ROUND_K[rnd_q]),
		.w      (w_cur),
		.v_next (v_round)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sbh_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (byte_present && (fill_q == 6'd63)) begin
						state_nxt = sbh_pkg::ST_COMP;
					end else if (end_of_message) begin
						state_nxt = sbh_pkg::ST_PAD;
					end
				end
			end
			sbh_pkg::ST_PAD: begin
				if (fill_q == 6'd63) begin
					state_nxt = sbh_pkg::ST_COMP;
				end
			end
			sbh_pkg::ST_COMP: begin
				if (rnd_q == 6'd63) begin
					state_nxt = sbh_pkg::ST_ADD;
				end
			end
			sbh_pkg::ST_ADD: begin
				if (fin_q && len_ok_q) begin
					state_nxt = sbh_pkg::ST_OUT;
				end else if (fin_q) begin
					state_nxt = sbh_pkg::ST_PAD;
				end else begin
					state_nxt = sbh_pkg::ST_IDLE;
				end
			end
			sbh_pkg::ST_OUT: begin
				if (out_ready && (idx_q == 3'd7)) begin
					state_nxt = sbh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = sbh_pkg::ST_IDLE;
			end
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			sbh_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			sbh_pkg::ST_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready  = 1'b0;
				out_valid = 1'b0;
			end
		endcase
	end

	assign comp_start  = (state_nxt == sbh_pkg::ST_COMP) && (state_q != sbh_pkg::ST_COMP);
	assign digest_word = h_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd7);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sbh_pkg::ST_IDLE;
			fill_q   <= '0;
			total_q  <= '0;
			fin_q    <= 1'b0;
			mark_q   <= 1'b0;
			len_ok_q <= 1'b0;
			rnd_q    <= '0;
			idx_q    <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sbh_pkg::INIT_H[i];
			end
		end else begin
			state_q <= state_nxt;

			// fill count wraps to zero as the block closes
			if (absorb) begin
				fill_q <= fill_q + 6'd1;
			end
			if (absorb_user) begin
				total_q <= total_q + 61'd1;
			end
			if (in_take && end_of_message) begin
				fin_q <= 1'b1;
			end

			// marker placed below the length field means this block is the last
			if ((state_q == sbh_pkg::ST_PAD) && !mark_q) begin
				mark_q <= 1'b1;
				if (fill_q < sbh_pkg::LEN_POS) begin
					len_ok_q <= 1'b1;
				end
			end

			if (state_q == sbh_pkg::ST_COMP) begin
				rnd_q <= rnd_q + 6'd1;
			end

			if (state_q == sbh_pkg::ST_ADD) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
				// spill block done, the next one holds the length
				if (fin_q && mark_q) begin
					len_ok_q <= 1'b1;
				end
			end

			if (out_take) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					total_q  <= '0;
					fin_q    <= 1'b0;
					mark_q   <= 1'b0;
					len_ok_q <= 1'b0;
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= sbh_pkg::INIT_H[i];
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (absorb) begin
			acc_q <= {acc_q[15:0], absorb_byte};
		end
		if (comp_start) begin
			v_q <= h_q;
		end else if (state_q == sbh_pkg::ST_COMP) begin
			v_q <= v_round;
		end
	end

endmodule
